// ----- design/sphere_touching_two_planes_and_sphere_core_macros.svh -----
// assertion macros shared by the sphere placement core
// expects i_clk and i_rst_n in the scope of each use
`ifndef SPHERE_TOUCHING_TWO_PLANES_AND_SPHERE_CORE_MACROS_SVH
`define SPHERE_TOUCHING_TWO_PLANES_AND_SPHERE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define STPS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("assertion failed: lbl");
`define STPS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");
`define STPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");
`else
`define STPS_ASSERT_NEVER(lbl, cond)
`define STPS_ASSERT_IMPL(lbl, ante, cons)
`define STPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/stps_pkg.sv -----
// shared widths, types and saturation helpers of the sphere placement core
// no dependencies
package stps_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 8;

    localparam int RAD_W   = 15;
    localparam int KIND_W  = 2;
    localparam int FIX_W   = RAD_W + FRAC_BITS;
    localparam int MAX_W   = (FIX_W > COORD_WIDTH) ? FIX_W : COORD_WIDTH;
    localparam int DIFF_W  = MAX_W + 2;
    localparam int ABS_W   = MAX_W + 1;
    localparam int BIG_W   = RAD_W + 1 + FRAC_BITS;
    localparam int RADC_W  = 2 * BIG_W;
    localparam int REM_W   = BIG_W + 3;
    localparam int SUM_W   = ((COORD_WIDTH > BIG_W + 1) ? COORD_WIDTH : BIG_W + 1) + 2;

    localparam int IN_FIELDS_W  = 3 * RAD_W + 3 * COORD_WIDTH;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_USER_W    = 2 * KIND_W;
    localparam int OUT_FIELDS_W = 6 * COORD_WIDTH;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [KIND_W-1:0] KIND_YZ = 2'd0;
    localparam logic [KIND_W-1:0] KIND_XZ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_XY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SUM = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]             k1;
        logic [KIND_W-1:0]             k2;
        logic [RAD_W-1:0]              pos1;
        logic [RAD_W-1:0]              pos2;
        logic [RAD_W-1:0]              r2;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
    } t_query;

    typedef struct packed {
        logic                          bad;
        logic [KIND_W-1:0]             k1;
        logic [KIND_W-1:0]             k2;
        logic [KIND_W-1:0]             kfree;
        logic [RAD_W-1:0]              fix1;
        logic [RAD_W-1:0]              fix2;
        logic signed [COORD_WIDTH-1:0] cfree;
    } t_ctl;

    typedef struct packed {
        t_ctl             ctl;
        logic [ABS_W-1:0] ad1;
        logic [ABS_W-1:0] ad2;
        logic [RAD_W:0]   rsum;
    } t_job;

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed({{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[COORD_WIDTH-1:0];
        end else if (v < lo) begin
            return lo[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_fix(input logic [RAD_W-1:0] f);
        logic [SUM_W-1:0] t;
        t = SUM_W'(f);
        t = t << FRAC_BITS;
        return sat_coord($signed(t));
    endfunction

endpackage

// ----- design/sphere_touching_two_planes_and_sphere_core.sv -----
// sphere placement core: centre of a new sphere touching two planes and a sphere
// pipeline: 2 front stages, the job queue, then BIG_W + 5 back stages
// throughput: one query per cycle while the output is not stalled, set by the one-bit-per-stage square root pipeline
// a stalled output freezes the back pipeline; the 4-entry queue keeps the front accepting until it fills
// reset (synchronous, active low) empties all stages and the queue, new_radius returns to 1
// depends on stps_pkg, stps_front, stps_fifo, stps_back and the macro header
`include "sphere_touching_two_planes_and_sphere_core_macros.svh"
module sphere_touching_two_planes_and_sphere_core import stps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [RAD_W-1:0]      i_cfg_wr_data,   // new_radius
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // first_plane_position, second_plane_position, other_radius,
    // other_center_x, other_center_y, other_center_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // first_plane_kind, second_plane_kind
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hole_a_x, hole_a_y, hole_a_z, hole_b_x, hole_b_y, hole_b_z
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // no_contact, bad_plane_pair
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    // radius register; the user must write it only while the core is idle, the core does not enforce this
    logic [RAD_W-1:0] r_new_radius;

    t_query query;
    t_job   front_job, head_job;
    logic   push, full, pop, empty;
    logic   nc, bad;
    logic [2:0][COORD_WIDTH-1:0] hole_a, hole_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_radius <= RAD_W'(1);
        end else if (i_cfg_wr_en) begin
            r_new_radius <= i_cfg_wr_data;
        end
    end

    // unpack the input transfer
    always_comb begin
        query.k1   = s_axis_tuser[KIND_W-1:0];
        query.k2   = s_axis_tuser[2*KIND_W-1:KIND_W];
        query.pos1 = s_axis_tdata[RAD_W-1:0];
        query.pos2 = s_axis_tdata[2*RAD_W-1:RAD_W];
        query.r2   = s_axis_tdata[3*RAD_W-1:2*RAD_W];
        query.cx   = s_axis_tdata[3*RAD_W +: COORD_WIDTH];
        query.cy   = s_axis_tdata[3*RAD_W+COORD_WIDTH +: COORD_WIDTH];
        query.cz   = s_axis_tdata[3*RAD_W+2*COORD_WIDTH +: COORD_WIDTH];
    end

    // front end: plane classification and axis distances
    stps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_new_radius (r_new_radius),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_query      (query),
        .o_push       (push),
        .i_full       (full),
        .o_job        (front_job)
    );

    // queue decoupling the two ends
    stps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    // back end: squares, root, output register
    stps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_a     (hole_a),
        .o_b     (hole_b),
        .o_nc    (nc),
        .o_bad   (bad)
    );

    // pack the result transfer, x lowest
    assign m_axis_tdata = OUT_DATA_W'({hole_b[2], hole_b[1], hole_b[0],
                                       hole_a[2], hole_a[1], hole_a[0]});
    assign m_axis_tuser = {bad, nc};

    // a bad plane pair never also reports no contact
    `STPS_ASSERT_NEVER(a_flags_exclusive, m_axis_tvalid && nc && bad)
    // a bad plane pair gives all-zero coordinates
    `STPS_ASSERT_IMPL(a_bad_zero, m_axis_tvalid && bad, m_axis_tdata == '0)
    // a radius write lands in the register on the next cycle
    `STPS_ASSERT_NEXT(a_cfg_write, i_cfg_wr_en, r_new_radius == $past(i_cfg_wr_data))

endmodule

// ----- design/stps_front.sv -----
// front end: classifies the plane pair and forms the axis distances
// depends on stps_pkg
module stps_front import stps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [RAD_W-1:0] i_new_radius,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_query           i_query,
    output logic             o_push,
    input  logic             i_full,
    output t_job             o_job
);

    logic                          r_v1, r_v2;
    t_ctl                          r_ctl1, r_ctl2;
    logic signed [COORD_WIDTH-1:0] r_c1, r_c2;
    logic [RAD_W:0]                r_rsum1, r_rsum2;
    logic [ABS_W-1:0]              r_ad1, r_ad2;

    logic                          adv2, load1;
    t_ctl                          n_ctl;
    logic [RAD_W:0]                dr1, dr2;
    logic signed [DIFF_W-1:0]      f1w, f2w, d1, d2;

    function automatic logic signed [COORD_WIDTH-1:0] sel_axis(
        input logic [KIND_W-1:0] k, input t_query q);
        case (k)
            KIND_YZ: return q.cx;
            KIND_XZ: return q.cy;
            KIND_XY: return q.cz;
            default: return '0;
        endcase
    endfunction

    assign adv2    = !r_v2 || !i_full;
    assign o_ready = adv2 || !r_v1;
    assign load1   = o_ready;
    assign o_push  = r_v2 && !i_full;
    assign o_job   = '{ctl: r_ctl2, ad1: r_ad1, ad2: r_ad2, rsum: r_rsum2};

    always_comb begin
        dr1 = {1'b0, i_new_radius} - {1'b0, i_query.pos1};
        dr2 = {1'b0, i_new_radius} - {1'b0, i_query.pos2};
        n_ctl.bad   = (i_query.k1 == i_query.k2) || (i_query.k1 > KIND_XY) ||
                      (i_query.k2 > KIND_XY);
        n_ctl.k1    = i_query.k1;
        n_ctl.k2    = i_query.k2;
        n_ctl.kfree = KIND_SUM - i_query.k1 - i_query.k2;
        n_ctl.fix1  = dr1[RAD_W] ? RAD_W'(-dr1) : dr1[RAD_W-1:0];
        n_ctl.fix2  = dr2[RAD_W] ? RAD_W'(-dr2) : dr2[RAD_W-1:0];
        n_ctl.cfree = sel_axis(n_ctl.kfree, i_query);
    end

    // signed distance of each fixed coordinate from the placed centre
    always_comb begin
        f1w = $signed(DIFF_W'(r_ctl1.fix1) << FRAC_BITS);
        f2w = $signed(DIFF_W'(r_ctl1.fix2) << FRAC_BITS);
        d1  = f1w - DIFF_W'(r_c1);
        d2  = f2w - DIFF_W'(r_c2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (load1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_ctl1  <= n_ctl;
            r_c1    <= sel_axis(i_query.k1, i_query);
            r_c2    <= sel_axis(i_query.k2, i_query);
            r_rsum1 <= {1'b0, i_new_radius} + {1'b0, i_query.r2};
        end
        if (adv2) begin
            r_ctl2  <= r_ctl1;
            r_rsum2 <= r_rsum1;
            r_ad1   <= d1[DIFF_W-1] ? ABS_W'(-d1) : ABS_W'(d1);
            r_ad2   <= d2[DIFF_W-1] ? ABS_W'(-d2) : ABS_W'(d2);
        end
    end

endmodule

// ----- design/stps_fifo.sv -----
// short job queue between front and back ends, head visible without a read
// depends on stps_pkg
module stps_fifo import stps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- design/stps_back.sv -----
// back end: squares, radicand, pipelined square root and output assembly
// depends on stps_pkg
module stps_back import stps_pkg::*; (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  t_job                                 i_job,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [2:0][COORD_WIDTH-1:0]          o_a,
    output logic [2:0][COORD_WIDTH-1:0]          o_b,
    output logic                                 o_nc,
    output logic                                 o_bad
);

    typedef struct packed {
        logic              v;
        t_ctl              ctl;
        logic              nc;
        logic [RADC_W-1:0] n;
        logic [REM_W-1:0]  rem;
        logic [BIG_W-1:0]  q;
    } t_sq;

    logic              adv;
    logic              r_va, r_vb, r_vc;
    t_ctl              r_ctla, r_ctlb, r_ctlc;
    logic              r_nca, r_ncb, r_ncc;
    logic [RADC_W-1:0] r_big2, r_sq1, r_sq2, r_n;
    logic [BIG_W:0]    r_root;
    t_sq               r_sq [BIG_W+1];
    logic              r_ov, r_onc, r_obad;
    logic [2:0][COORD_WIDTH-1:0] r_oa, r_ob;

    logic [BIG_W-1:0]            big;
    logic signed [RADC_W+1:0]    radic;
    logic signed [SUM_W-1:0]     rootw, sum_a, sum_b;
    logic [2:0][COORD_WIDTH-1:0] n_oa, n_ob;

    function automatic t_sq sqrt_step(input t_sq s);
        t_sq              r;
        logic [REM_W-1:0] rs, trial;
        r     = s;
        rs    = {s.rem[REM_W-3:0], s.n[RADC_W-1:RADC_W-2]};
        trial = {1'b0, s.q, 2'b01};
        r.n   = s.n << 2;
        if (rs >= trial) begin
            r.rem = rs - trial;
            r.q   = {s.q[BIG_W-2:0], 1'b1};
        end else begin
            r.rem = rs;
            r.q   = {s.q[BIG_W-2:0], 1'b0};
        end
        return r;
    endfunction

    assign adv     = !r_ov || i_ready;
    assign o_pop   = adv && !i_empty;
    assign o_valid = r_ov;
    assign o_a     = r_oa;
    assign o_b     = r_ob;
    assign o_nc    = r_onc;
    assign o_bad   = r_obad;

    assign big   = BIG_W'(i_job.rsum) << FRAC_BITS;
    assign radic = $signed({2'b00, r_big2}) - $signed({2'b00, r_sq1}) -
                   $signed({2'b00, r_sq2});

    // stage a: range check and the three squares
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctla <= i_job.ctl;
            r_nca  <= (i_job.ad1 > ABS_W'(big)) || (i_job.ad2 > ABS_W'(big));
            r_big2 <= big * big;
            r_sq1  <= i_job.ad1[BIG_W-1:0] * i_job.ad1[BIG_W-1:0];
            r_sq2  <= i_job.ad2[BIG_W-1:0] * i_job.ad2[BIG_W-1:0];
        end
    end

    // stage b: radicand and its sign
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctlb <= r_ctla;
            r_ncb  <= r_nca || radic[RADC_W+1];
            r_n    <= (r_nca || radic[RADC_W+1]) ? '0 : radic[RADC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq[0].v   <= r_vb;
            r_sq[0].ctl <= r_ctlb;
            r_sq[0].nc  <= r_ncb;
            r_sq[0].n   <= r_n;
            r_sq[0].rem <= '0;
            r_sq[0].q   <= '0;
        end
    end

    // one root bit per stage
    for (genvar g = 0; g < BIG_W; g++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[g+1].v <= 1'b0;
            end else if (adv) begin
                r_sq[g+1] <= sqrt_step(r_sq[g]);
            end
        end
    end

    // round to nearest: remainder above the root means the upper neighbor is closer
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctlc <= r_sq[BIG_W].ctl;
            r_ncc  <= r_sq[BIG_W].nc;
            if (r_sq[BIG_W].rem > REM_W'(r_sq[BIG_W].q)) begin
                r_root <= {1'b0, r_sq[BIG_W].q} + 1'b1;
            end else begin
                r_root <= {1'b0, r_sq[BIG_W].q};
            end
        end
    end

    always_comb begin
        rootw = $signed(SUM_W'(r_root));
        sum_a = SUM_W'(r_ctlc.cfree) + rootw;
        sum_b = SUM_W'(r_ctlc.cfree) - rootw;
        for (int ax = 0; ax < 3; ax++) begin
            if (r_ctlc.bad) begin
                n_oa[ax] = '0;
                n_ob[ax] = '0;
            end else if (KIND_W'(ax) == r_ctlc.k1) begin
                n_oa[ax] = sat_fix(r_ctlc.fix1);
                n_ob[ax] = n_oa[ax];
            end else if (KIND_W'(ax) == r_ctlc.k2) begin
                n_oa[ax] = sat_fix(r_ctlc.fix2);
                n_ob[ax] = n_oa[ax];
            end else if (r_ncc) begin
                n_oa[ax] = '0;
                n_ob[ax] = '0;
            end else begin
                n_oa[ax] = sat_coord(sum_a);
                n_ob[ax] = sat_coord(sum_b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_oa   <= n_oa;
            r_ob   <= n_ob;
            r_onc  <= r_ncc && !r_ctlc.bad;
            r_obad <= r_ctlc.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_va <= !i_empty;
            r_vb <= r_va;
            r_vc <= r_sq[BIG_W].v;
            r_ov <= r_vc;
        end
    end

endmodule

// ----- bench/sphere_touching_two_planes_and_sphere_core_tb.sv -----
// self-checking bench for the sphere placement core: directed table, then random queries
// holes are predicted in-bench and compared per field; depends on stps_pkg and the core rtl
`timescale 1ns / 100ps
module sphere_touching_two_planes_and_sphere_core_tb;
    import stps_pkg::*;

    // one result: two candidate centres plus the two flags
    typedef struct {
        logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz;
        logic                          nc;
        logic                          bad;
    } t_hole;

    // directed row: query, and a typed-in hole where it is obvious
    typedef struct {
        t_query q;
        bit     typed;
        t_hole  hole;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [RAD_W-1:0]      i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    t_hole       pending_holes[$];
    int          fail_count = 0;
    int          rx_hold_cycles = 0;
    bit          no_idle = 1'b0;
    logic [RAD_W-1:0] radius_setting = RAD_W'(1);

    sphere_touching_two_planes_and_sphere_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // generous ceiling, far above the slowest correct run
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_coord(input longint v);
        longint top;
        top = (longint'(1) << (COORD_WIDTH - 1)) - 1;
        if (v > top) return top;
        if (v < -top - 1) return -top - 1;
        return v;
    endfunction

    // bitwise integer square root, floor
    function automatic longint floor_root(input longint n);
        longint acc;
        longint probe;
        acc = 0;
        probe = longint'(1) << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= acc + probe) begin
                n = n - (acc + probe);
                acc = (acc >> 1) + probe;
            end else begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        return acc;
    endfunction

    // candidate centres of a sphere of radius nr touching both planes and the placed sphere
    function automatic t_hole place_sphere(input t_query q, input logic [RAD_W-1:0] nr);
        t_hole  h;
        longint ctr[3];
        longint a[3];
        longint b[3];
        longint fix1, fix2, d1, d2, reach, span, left, root;
        int     free_axis;
        h = '{default: '0};
        if (q.k1 == KIND_SUM || q.k2 == KIND_SUM || q.k1 == q.k2) begin
            h.bad = 1'b1;
            return h;
        end
        ctr[0] = q.cx;
        ctr[1] = q.cy;
        ctr[2] = q.cz;
        free_axis = 3 - int'(q.k1) - int'(q.k2);
        fix1 = mag(longint'(nr) - longint'(q.pos1)) << FRAC_BITS;
        fix2 = mag(longint'(nr) - longint'(q.pos2)) << FRAC_BITS;
        a[q.k1] = clamp_coord(fix1);
        b[q.k1] = a[q.k1];
        a[q.k2] = clamp_coord(fix2);
        b[q.k2] = a[q.k2];
        a[free_axis] = 0;
        b[free_axis] = 0;
        d1 = mag(fix1 - ctr[q.k1]);
        d2 = mag(fix2 - ctr[q.k2]);
        reach = (longint'(nr) + longint'(q.r2)) << FRAC_BITS;
        span = reach * reach;
        // radicand below zero: no touching position, free axis left at zero
        if (d1 > reach || d2 > reach || d1 * d1 + d2 * d2 > span) begin
            h.nc = 1'b1;
        end else begin
            left = span - d1 * d1 - d2 * d2;
            root = floor_root(left);
            if (left - root * root > root) root++;
            a[free_axis] = clamp_coord(ctr[free_axis] + root);
            b[free_axis] = clamp_coord(ctr[free_axis] - root);
        end
        h.ax = COORD_WIDTH'(a[0]); h.ay = COORD_WIDTH'(a[1]); h.az = COORD_WIDTH'(a[2]);
        h.bx = COORD_WIDTH'(b[0]); h.by = COORD_WIDTH'(b[1]); h.bz = COORD_WIDTH'(b[2]);
        return h;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    // result side: compare every accepted transfer with the oldest pending hole
    always @(posedge i_clk) begin
        t_hole want;
        t_hole got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ax = m_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH];
            got.ay = m_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH];
            got.az = m_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
            got.bx = m_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH];
            got.by = m_axis_tdata[4*COORD_WIDTH +: COORD_WIDTH];
            got.bz = m_axis_tdata[5*COORD_WIDTH +: COORD_WIDTH];
            got.nc = m_axis_tuser[0];
            got.bad = m_axis_tuser[1];
            if (pending_holes.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = pending_holes.pop_front();
                if (got.ax != want.ax) report_mismatch("hole_a_x", got.ax, want.ax);
                if (got.ay != want.ay) report_mismatch("hole_a_y", got.ay, want.ay);
                if (got.az != want.az) report_mismatch("hole_a_z", got.az, want.az);
                if (got.bx != want.bx) report_mismatch("hole_b_x", got.bx, want.bx);
                if (got.by != want.by) report_mismatch("hole_b_y", got.by, want.by);
                if (got.bz != want.bz) report_mismatch("hole_b_z", got.bz, want.bz);
                if (got.nc != want.nc) report_mismatch("no_contact", got.nc, want.nc);
                if (got.bad != want.bad) report_mismatch("bad_plane_pair", got.bad, want.bad);
            end
        end
    end

    // receiver: random back-pressure, plus a long hold-off counted here
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_axis_tready = 1'b0;
            end else if (no_idle) begin
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= 18);
            end
        end
    end

    // offer one query until the core takes it, then queue its prediction
    task automatic send_query(input t_query q, input t_hole want);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = IN_DATA_W'({q.cz, q.cy, q.cx, q.r2, q.pos2, q.pos1});
        s_axis_tuser = {q.k2, q.k1};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_holes.insert(pending_holes.size(), want);
        @(negedge i_clk);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 18) begin
                s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
    endtask

    // only while the core is empty: drain, let the pipeline settle, then write
    task automatic set_radius(input logic [RAD_W-1:0] nr);
        s_axis_tvalid = 1'b0;
        while (pending_holes.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = nr;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        radius_setting = nr;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] near_coord(input longint fix,
                                                                 input longint reach);
        longint off;
        off = $urandom_range(0, int'(reach));
        if ($urandom_range(0, 1)) off = -off;
        return COORD_WIDTH'(clamp_coord(fix + off));
    endfunction

    // mostly valid plane pairs with centres close enough to touch, some noise
    function automatic t_query random_query(input logic [RAD_W-1:0] nr);
        t_query q;
        longint reach;
        logic signed [COORD_WIDTH-1:0] ctr[3];
        q.k1 = KIND_W'($urandom_range(0, 3));
        q.k2 = KIND_W'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 90) begin
            q.k1 = KIND_W'($urandom_range(0, 2));
            q.k2 = KIND_W'((q.k1 + $urandom_range(1, 2)) % 3);
        end
        if ($urandom_range(0, 3) == 0) begin
            q.pos1 = RAD_W'($urandom);
            q.pos2 = RAD_W'($urandom);
        end else begin
            q.pos1 = RAD_W'(nr + $urandom_range(0, 512) - 256);
            q.pos2 = RAD_W'(nr + $urandom_range(0, 512) - 256);
        end
        q.r2 = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 600));
        ctr[0] = COORD_WIDTH'($urandom);
        ctr[1] = COORD_WIDTH'($urandom);
        ctr[2] = COORD_WIDTH'($urandom);
        reach = (longint'(nr) + longint'(q.r2)) << FRAC_BITS;
        if (q.k1 != KIND_SUM && $urandom_range(0, 99) < 80)
            ctr[q.k1] = near_coord(mag(longint'(nr) - longint'(q.pos1)) << FRAC_BITS, reach);
        if (q.k2 != KIND_SUM && $urandom_range(0, 99) < 80)
            ctr[q.k2] = near_coord(mag(longint'(nr) - longint'(q.pos2)) << FRAC_BITS, reach);
        q.cx = ctr[0];
        q.cy = ctr[1];
        q.cz = ctr[2];
        return q;
    endfunction

    function automatic t_row row(input logic [1:0] k1, input int p1, input logic [1:0] k2,
                                 input int p2, input int r2, input int x, input int y,
                                 input int z);
        t_row r;
        r.q = '{k1: k1, k2: k2, pos1: RAD_W'(p1), pos2: RAD_W'(p2), r2: RAD_W'(r2),
                cx: COORD_WIDTH'(x), cy: COORD_WIDTH'(y), cz: COORD_WIDTH'(z)};
        r.typed = 1'b0;
        r.hole = '{default: '0};
        return r;
    endfunction

    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;
    localparam int PMAX = 32767;

    t_row stimulus_table[$];

    initial begin
        t_row r;
        t_hole want;
        logic [RAD_W-1:0] radius_plan[4];
        int n;

        // directed rows, all under the reset radius of 1
        r = row(KIND_YZ, 1, KIND_XZ, 1, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.hole.az = 256;
        r.hole.bz = -256;
        stimulus_table.insert(stimulus_table.size(), r);
        r = row(KIND_XY, 5, KIND_XY, 9, 3, 100, -100, 7);
        r.typed = 1'b1;
        r.hole.bad = 1'b1;
        stimulus_table.insert(stimulus_table.size(), r);
        r = row(KIND_SUM, 0, KIND_YZ, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.hole.bad = 1'b1;
        stimulus_table.insert(stimulus_table.size(), r);
        r = row(KIND_XZ, PMAX, KIND_SUM, PMAX, PMAX, CMAX, CMIN, CMAX);
        r.typed = 1'b1;
        r.hole.bad = 1'b1;
        stimulus_table.insert(stimulus_table.size(), r);
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_XZ, 1, KIND_YZ, 2, 4, 0, 512, 1000));
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_YZ, 0, KIND_XY, 3, 10, 300, -5000, 400));
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_XY, 2, KIND_YZ, 1, 1, 200, 77, 300));
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_XZ, 0, KIND_XY, 0, 2, 12345, 256, -256));
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_XY, 7, KIND_XZ, 1, 8, 1, 0, 1536));
        // placed sphere too far away: no contact
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_YZ, 1, KIND_XZ, 1, 0, CMAX, CMIN, 0));
        // largest placed-sphere radius, largest and zero plane positions, extreme centres
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_YZ, PMAX, KIND_XZ, PMAX, PMAX, CMAX, CMAX, CMAX));
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_XZ, PMAX, KIND_XY, 0, PMAX, CMIN, CMAX, 0));
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_XY, 0, KIND_YZ, PMAX, PMAX, CMAX, CMIN, CMIN));
        // free axis pushed past the coordinate range: saturation both ways
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_YZ, 1, KIND_XZ, 1, PMAX, 0, 0, CMAX));
        stimulus_table.insert(stimulus_table.size(),
                              row(KIND_YZ, 1, KIND_XY, 1, PMAX, 0, CMIN, 0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (stimulus_table[i]) begin
            want = stimulus_table[i].typed ? stimulus_table[i].hole
                                           : place_sphere(stimulus_table[i].q, radius_setting);
            send_query(stimulus_table[i].q, want);
        end

        // random phases under several radius settings, extremes among them
        radius_plan[0] = RAD_W'(PMAX);
        radius_plan[1] = RAD_W'(1);
        radius_plan[2] = RAD_W'(200);
        radius_plan[3] = RAD_W'($urandom_range(2, PMAX - 1));
        n = 0;
        foreach (radius_plan[p]) begin
            set_radius(radius_plan[p]);
            repeat (235) begin
                t_query q;
                // long stall at the output while queries keep coming
                if (n == 100) rx_hold_cycles = 400;
                no_idle = (n >= 400 && n < 560);
                // sender waits until every pending hole has arrived
                if (n == 700) begin
                    s_axis_tvalid = 1'b0;
                    while (pending_holes.size() != 0) @(negedge i_clk);
                end
                q = random_query(radius_setting);
                send_query(q, place_sphere(q, radius_setting));
                n++;
            end
        end
        s_axis_tvalid = 1'b0;
        no_idle = 1'b0;

        while (pending_holes.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/stps_pkg.sv
design/stps_front.sv
design/stps_fifo.sv
design/stps_back.sv
design/sphere_touching_two_planes_and_sphere_core.sv
bench/sphere_touching_two_planes_and_sphere_core_tb.sv
